FILE: rtl/core/bf3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 box filter frame unit.
// No dependencies.
package bf3_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 7;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int NBHD       = 9;
    localparam int SUM_W      = $clog2(NBHD * 255 + 1);
    localparam int CNT_W      = $clog2(NBHD + 1);
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FILTER = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OOF    = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES = 2'd2;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 7'd64;
    localparam logic [7:0]       RST_PASSES = 8'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] pixel_index;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [1:0] status;
    } t_out_item;

endpackage

FILE: rtl/core/box_filter_3x3_frame_iterated_unit.sv
`timescale 1ns / 1ps
// Top level of the 3x3 box filter frame unit: ping-pong frame banks, sequencer,
// neighbor accumulator and shared 12-step divider. Depends on bf3_pkg.
//
// Holds one RGB frame in two 4096 x 24 banks. A load gives a beat only when the
// index is out of frame. A read registers the bank word, then the output beat. A
// filter request walks every pixel, once per pass, through one shared sequencer:
// nine neighbor reads, each an address state and an accumulate state, a
// restoring divide on all three channels, then one write; the done beat follows
// the last pass. The block takes no new item until the current one is finished
// and the output register is free or being drained.
module box_filter_3x3_frame_iterated_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bf3_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bf3_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bf3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bf3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PASS,
        S_NADDR,
        S_NACC,
        S_DIV,
        S_WRITE
    } t_state;

    localparam logic [1:0] NB_LO  = 2'd0;
    localparam logic [1:0] NB_MID = 2'd1;
    localparam logic [1:0] NB_HI  = 2'd2;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    t_state              r_state;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic                r_active;
    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [7:0]          r_passes;
    logic [7:0]          r_pass_left;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ADDR_W-1:0]   r_base;
    logic [1:0]          r_dr;
    logic [1:0]          r_dc;
    logic                r_take;
    logic [SUM_W-1:0]    r_num [NUM_CH];
    logic [CNT_W-1:0]    r_rem [NUM_CH];
    logic [CNT_W-1:0]    r_cnt;
    logic [STEP_W-1:0]   r_step;

    logic [PIX_W-1:0]    r_bank_a [DEPTH];
    logic [PIX_W-1:0]    r_bank_b [DEPTH];
    logic [PIX_W-1:0]    r_rd_a;
    logic [PIX_W-1:0]    r_rd_b;

    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [DIM_W-1:0]    w_m1;
    logic [DIM_W-1:0]    h_m1;
    logic [COL_W-1:0]    col_last;
    logic [ROW_W-1:0]    row_last;
    logic [AREA_W-1:0]   area;
    logic                in_ok;
    logic                in_accept;
    logic [PIX_W-1:0]    rd_src;
    logic                nb_in;
    logic [ADDR_W-1:0]   nb_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic                wr_bank;
    logic [ADDR_W-1:0]   wr_addr;
    logic [PIX_W-1:0]    wr_data;
    logic [CNT_W:0]      div_sh  [NUM_CH];
    logic                div_ge  [NUM_CH];
    logic [CNT_W-1:0]    div_rem [NUM_CH];

    assign w_eff    = eff_dim(r_width, DIM_W'(MAX_WIDTH));
    assign h_eff    = eff_dim(r_height, DIM_W'(MAX_HEIGHT));
    assign w_m1     = w_eff - DIM_W'(1);
    assign h_m1     = h_eff - DIM_W'(1);
    assign col_last = w_m1[COL_W-1:0];
    assign row_last = h_m1[ROW_W-1:0];
    assign area     = AREA_W'(w_eff) * AREA_W'(h_eff);
    assign in_ok    = AREA_W'(i_in_item.pixel_index) < area;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    assign rd_src = r_active ? r_rd_b : r_rd_a;

    always_comb begin
        logic row_ok;
        logic col_ok;
        logic [ADDR_W-1:0] row_addr;
        row_ok = 1'b1;
        col_ok = 1'b1;
        row_addr = r_base;
        if (r_dr == NB_LO) begin
            row_ok   = (r_row != '0);
            row_addr = r_base - ADDR_W'(w_eff);
        end else if (r_dr == NB_HI) begin
            row_ok   = (r_row != row_last);
            row_addr = r_base + ADDR_W'(w_eff);
        end
        if (r_dc == NB_LO) begin
            col_ok  = (r_col != '0);
            nb_addr = row_addr - ADDR_W'(1);
        end else if (r_dc == NB_HI) begin
            col_ok  = (r_col != col_last);
            nb_addr = row_addr + ADDR_W'(1);
        end else begin
            nb_addr = row_addr;
        end
        nb_in = row_ok && col_ok;
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            div_sh[ch]  = {r_rem[ch], r_num[ch][SUM_W-1]};
            div_ge[ch]  = div_sh[ch] >= {1'b0, r_cnt};
            div_rem[ch] = div_ge[ch] ? CNT_W'(div_sh[ch] - {1'b0, r_cnt})
                                     : CNT_W'(div_sh[ch]);
        end
    end

    // Memory port steering
    always_comb begin
        rd_addr = (r_state == S_IDLE) ? ADDR_W'(i_in_item.pixel_index) : nb_addr;
        wr_en   = 1'b0;
        wr_bank = r_active;
        wr_addr = ADDR_W'(i_in_item.pixel_index);
        wr_data = {i_in_item.in_blue, i_in_item.in_green, i_in_item.in_red};
        if (r_state == S_WRITE) begin
            wr_en   = 1'b1;
            wr_bank = !r_active;
            wr_addr = r_base;
            wr_data = {r_num[2][CH_W-1:0], r_num[1][CH_W-1:0], r_num[0][CH_W-1:0]};
        end else if (in_accept && (i_in_item.op == OP_LOAD) && in_ok) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_bank) begin
            r_bank_a[wr_addr] <= wr_data;
        end
        r_rd_a <= r_bank_a[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_bank) begin
            r_bank_b[wr_addr] <= wr_data;
        end
        r_rd_b <= r_bank_b[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_passes    <= RST_PASSES;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    CFG_PASSES: r_passes <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (i_in_item.op)
                            OP_LOAD: begin
                                if (!in_ok) begin
                                    r_out_valid <= 1'b1;
                                    r_out_item  <= '{8'd0, 8'd0, 8'd0, ST_OOF};
                                end
                            end
                            OP_FILTER: begin
                                r_pass_left <= r_passes;
                                r_state     <= S_PASS;
                            end
                            OP_READ: begin
                                if (in_ok) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out_item  <= '{8'd0, 8'd0, 8'd0, ST_OOF};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_item  <= '{rd_src[7:0], rd_src[15:8], rd_src[23:16], ST_OK};
                    r_state     <= S_IDLE;
                end
                S_PASS: begin
                    if (r_pass_left == '0) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= '{8'd0, 8'd0, 8'd0, ST_DONE};
                        r_state     <= S_IDLE;
                    end else begin
                        r_row  <= '0;
                        r_col  <= '0;
                        r_base <= '0;
                        r_dr   <= NB_LO;
                        r_dc   <= NB_LO;
                        r_cnt  <= '0;
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            r_num[ch] <= '0;
                        end
                        r_state <= S_NADDR;
                    end
                end
                S_NADDR: begin
                    r_take  <= nb_in;
                    r_state <= S_NACC;
                end
                S_NACC: begin
                    if (r_take) begin
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            r_num[ch] <= r_num[ch] + SUM_W'(rd_src[ch*CH_W +: CH_W]);
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_dc == NB_HI) begin
                        r_dc <= NB_LO;
                        if (r_dr == NB_HI) begin
                            r_step <= '0;
                            for (int ch = 0; ch < NUM_CH; ch++) begin
                                r_rem[ch] <= '0;
                            end
                            r_state <= S_DIV;
                        end else begin
                            r_dr    <= r_dr + 2'd1;
                            r_state <= S_NADDR;
                        end
                    end else begin
                        r_dc    <= r_dc + 2'd1;
                        r_state <= S_NADDR;
                    end
                end
                S_DIV: begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        r_rem[ch] <= div_rem[ch];
                        r_num[ch] <= {r_num[ch][SUM_W-2:0], div_ge[ch]};
                    end
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_dr  <= NB_LO;
                    r_dc  <= NB_LO;
                    r_cnt <= '0;
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        r_num[ch] <= '0;
                    end
                    r_base <= r_base + ADDR_W'(1);
                    if (r_col == col_last) begin
                        r_col <= '0;
                        if (r_row == row_last) begin
                            r_active    <= !r_active;
                            r_pass_left <= r_pass_left - 8'd1;
                            r_state     <= S_PASS;
                        end else begin
                            r_row   <= r_row + ROW_W'(1);
                            r_state <= S_NADDR;
                        end
                    end else begin
                        r_col   <= r_col + COL_W'(1);
                        r_state <= S_NADDR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_cnt != '0) && (r_cnt <= CNT_W'(NBHD))))
        else $error("divisor out of range");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ((r_num[0][SUM_W-1:CH_W] == '0) &&
                                  (r_num[1][SUM_W-1:CH_W] == '0) &&
                                  (r_num[2][SUM_W-1:CH_W] == '0)))
        else $error("quotient wider than a channel");

    a_center_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_NADDR) && (r_dr == NB_MID) && (r_dc == NB_MID)) |-> nb_in)
        else $error("center pixel flagged out of frame");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite pending beat");

    a_pass_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && (r_col == col_last) && (r_row == row_last))
        |=> (r_active != $past(r_active)))
        else $error("bank swap missing at end of pass");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for box_filter_3x3_frame_iterated_unit: a directed table, then random
// frame phases, all beats checked against typed row answers or an in-bench frame store and
// box-blur predictor. Depends on bf3_pkg and the unit RTL.
module tb;
    import bf3_pkg::*;

    localparam logic [1:0]           OP_NONE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam int                   RANDOM_ITEMS = 1200;
    localparam int                   QUIET_ITEMS  = 150;
    localparam int                   DRAIN_CYCLES = 4;
    localparam t_out_item            NO_ANS       = '0;

    typedef struct packed {
        logic [7:0] blu;
        logic [7:0] grn;
        logic [7:0] red;
    } t_pix;

    typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        t_in_item              item;
        t_out_item             answer;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_pix             frame_mem [0:1][0:DEPTH-1];
    logic             active_sel;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [7:0]       passes_reg;

    t_out_item pixel_answers [$];
    int        error_count  = 0;
    int        random_done  = 0;
    int        gap_pct      = 0;
    int        stall_pct    = 0;
    bit        quiet        = 1'b0;
    longint    cycle_count  = 0;
    longint    cycle_budget = 50000;

    t_dir_row directed_rows [34] = '{
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd0, 8'd255, 8'd0, 8'd255}, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd4095, 8'd0, 8'd255, 8'd0}, NO_ANS},
        '{ROW_TYPED, '0, '0, '{OP_READ, 12'd0, 8'd0, 8'd0, 8'd0}, '{8'd255, 8'd0, 8'd255, ST_OK}},
        '{ROW_TYPED, '0, '0, '{OP_READ, 12'd4095, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0, ST_OK}},
        '{ROW_PRED,  '0, '0, '{OP_NONE, 12'd4095, 8'd255, 8'd255, 8'd255}, NO_ANS},
        '{ROW_CFG,   CFG_WIDTH,  8'd0, '0, NO_ANS},
        '{ROW_CFG,   CFG_HEIGHT, 8'd2, '0, NO_ANS},
        '{ROW_CFG,   CFG_PASSES, 8'd0, '0, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd0, 8'd10, 8'd20, 8'd30}, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd1, 8'd40, 8'd50, 8'd60}, NO_ANS},
        '{ROW_TYPED, '0, '0, '{OP_READ, 12'd2, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, ST_OOF}},
        '{ROW_TYPED, '0, '0, '{OP_LOAD, 12'd4095, 8'd255, 8'd255, 8'd255},
            '{8'd0, 8'd0, 8'd0, ST_OOF}},
        '{ROW_TYPED, '0, '0, '{OP_FILTER, 12'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, ST_DONE}},
        '{ROW_TYPED, '0, '0, '{OP_READ, 12'd1, 8'd0, 8'd0, 8'd0}, '{8'd40, 8'd50, 8'd60, ST_OK}},
        '{ROW_CFG,   CFG_PASSES, 8'd1, '0, NO_ANS},
        '{ROW_TYPED, '0, '0, '{OP_FILTER, 12'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, ST_DONE}},
        '{ROW_PRED,  '0, '0, '{OP_READ, 12'd0, 8'd0, 8'd0, 8'd0}, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_READ, 12'd1, 8'd0, 8'd0, 8'd0}, NO_ANS},
        '{ROW_CFG,   CFG_WIDTH,  8'd2, '0, NO_ANS},
        '{ROW_CFG,   CFG_HEIGHT, 8'd1, '0, NO_ANS},
        '{ROW_CFG,   CFG_PASSES, 8'd255, '0, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd0, 8'd255, 8'd255, 8'd255}, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd1, 8'd0, 8'd0, 8'd0}, NO_ANS},
        '{ROW_TYPED, '0, '0, '{OP_FILTER, 12'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, ST_DONE}},
        '{ROW_PRED,  '0, '0, '{OP_READ, 12'd0, 8'd0, 8'd0, 8'd0}, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_READ, 12'd1, 8'd0, 8'd0, 8'd0}, NO_ANS},
        '{ROW_CFG,   CFG_WIDTH,  8'd255, '0, NO_ANS},
        '{ROW_CFG,   CFG_HEIGHT, 8'd255, '0, NO_ANS},
        '{ROW_CFG,   CFG_PASSES, 8'd0, '0, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_LOAD, 12'd4095, 8'd170, 8'd85, 8'd1}, NO_ANS},
        '{ROW_TYPED, '0, '0, '{OP_READ, 12'd4095, 8'd0, 8'd0, 8'd0},
            '{8'd170, 8'd85, 8'd1, ST_OK}},
        '{ROW_TYPED, '0, '0, '{OP_FILTER, 12'd0, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0, ST_DONE}},
        '{ROW_CFG,   CFG_SPARE,  8'hA5, '0, NO_ANS},
        '{ROW_PRED,  '0, '0, '{OP_READ, 12'd4095, 8'd0, 8'd0, 8'd0}, NO_ANS}
    };

    box_filter_3x3_frame_iterated_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] raw, input int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return raw;
    endfunction

    // Applies one item to the frame store; returns 1 when the item yields a beat.
    function automatic bit frame_step(input t_in_item it, output t_out_item ans);
        int   w, h, k, r, c, dr, dc, nr, nc, cnt, sum_r, sum_g, sum_b;
        t_pix p, q;
        w   = eff_dim(width_reg, MAX_WIDTH);
        h   = eff_dim(height_reg, MAX_HEIGHT);
        ans = '0;
        case (it.op)
            OP_LOAD: begin
                if (it.pixel_index >= w * h) begin
                    ans.status = ST_OOF;
                    return 1'b1;
                end
                frame_mem[active_sel][it.pixel_index] = {it.in_blue, it.in_green, it.in_red};
                return 1'b0;
            end
            OP_FILTER: begin
                for (k = 0; k < passes_reg; k++) begin
                    for (r = 0; r < h; r++) begin
                        for (c = 0; c < w; c++) begin
                            sum_r = 0;
                            sum_g = 0;
                            sum_b = 0;
                            cnt   = 0;
                            for (dr = -1; dr <= 1; dr++) begin
                                for (dc = -1; dc <= 1; dc++) begin
                                    nr = r + dr;
                                    nc = c + dc;
                                    if (nr >= 0 && nr < h && nc >= 0 && nc < w) begin
                                        p = frame_mem[active_sel][nr * w + nc];
                                        sum_r += p.red;
                                        sum_g += p.grn;
                                        sum_b += p.blu;
                                        cnt++;
                                    end
                                end
                            end
                            q.red = 8'(sum_r / cnt);
                            q.grn = 8'(sum_g / cnt);
                            q.blu = 8'(sum_b / cnt);
                            frame_mem[~active_sel][r * w + c] = q;
                        end
                    end
                    active_sel = ~active_sel;
                end
                ans.status = ST_DONE;
                return 1'b1;
            end
            OP_READ: begin
                if (it.pixel_index >= w * h) begin
                    ans.status = ST_OOF;
                    return 1'b1;
                end
                p             = frame_mem[active_sel][it.pixel_index];
                ans.out_red   = p.red;
                ans.out_green = p.grn;
                ans.out_blue  = p.blu;
                ans.status    = ST_OK;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_item(input t_in_item it, input bit typed, input t_out_item typed_ans);
        t_out_item ans;
        bit        has_ans;
        cycle_budget += 40;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.op == OP_FILTER)
            cycle_budget += longint'(passes_reg) * (31 * eff_dim(width_reg, MAX_WIDTH)
                * eff_dim(height_reg, MAX_HEIGHT) + 1) + 4;
        has_ans = frame_step(it, ans);
        if (typed) begin
            has_ans = 1'b1;
            ans     = typed_ans;
        end
        if (has_ans) pixel_answers.push_back(ans);
    endtask

    task automatic sender_gap();
        quiet = random_done >= RANDOM_ITEMS - QUIET_ITEMS;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain_answers();
        i_in_valid <= 1'b0;
        while (pixel_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cycle_budget += 50;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WIDTH:  width_reg  = data[DIM_W-1:0];
            CFG_HEIGHT: height_reg = data[DIM_W-1:0];
            CFG_PASSES: passes_reg = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4 * cycle_budget) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        forever begin
            if (quiet || $urandom_range(0, 99) >= stall_pct) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_answers.size() == 0) begin
                $error("unexpected beat: status %0d", o_out_item.status);
                error_count++;
            end else begin
                want = pixel_answers.pop_front();
                if (o_out_item.out_red !== want.out_red) begin
                    $error("out_red: expected %0d, got %0d", want.out_red, o_out_item.out_red);
                    error_count++;
                end
                if (o_out_item.out_green !== want.out_green) begin
                    $error("out_green: expected %0d, got %0d",
                           want.out_green, o_out_item.out_green);
                    error_count++;
                end
                if (o_out_item.out_blue !== want.out_blue) begin
                    $error("out_blue: expected %0d, got %0d",
                           want.out_blue, o_out_item.out_blue);
                    error_count++;
                end
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int               sel, j, mix, frame_px;
        logic [DIM_W-1:0] wv, hv;
        logic [7:0]       pv;
        t_in_item         it;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        active_sel  = 1'b0;
        width_reg   = RST_WIDTH;
        height_reg  = RST_HEIGHT;
        passes_reg  = RST_PASSES;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 30;
        stall_pct = 30;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_answers();
                write_reg(directed_rows[i].cfg_index, directed_rows[i].cfg_data);
            end else begin
                sender_gap();
                push_item(directed_rows[i].item, directed_rows[i].kind == ROW_TYPED,
                          directed_rows[i].answer);
            end
        end

        while (random_done < RANDOM_ITEMS) begin
            drain_answers();
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 40;
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    wv = DIM_W'($urandom_range(64, 127));
                    hv = DIM_W'($urandom_range(0, 1));
                    pv = 8'($urandom_range(1, 2));
                end
                1: begin
                    wv = DIM_W'($urandom_range(0, 1));
                    hv = DIM_W'($urandom_range(64, 127));
                    pv = 8'd1;
                end
                2: begin
                    wv = DIM_W'($urandom_range(1, 2));
                    hv = DIM_W'($urandom_range(1, 2));
                    pv = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(200, 254));
                end
                default: begin
                    wv = DIM_W'($urandom_range(0, 8));
                    hv = DIM_W'($urandom_range(0, 8));
                    pv = 8'($urandom_range(0, 3));
                end
            endcase
            write_reg(CFG_WIDTH, {$urandom_range(0, 1) == 1, wv});
            write_reg(CFG_HEIGHT, {$urandom_range(0, 1) == 1, hv});
            write_reg(CFG_PASSES, pv);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
            frame_px = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);

            for (j = 0; j < frame_px; j++) begin
                it = {OP_LOAD, 12'(j), 24'($urandom)};
                sender_gap();
                push_item(it, 1'b0, NO_ANS);
                random_done++;
            end

            mix = $urandom_range(30, 60);
            for (j = 0; j < mix && random_done < RANDOM_ITEMS; j++) begin
                sel = $urandom_range(0, 99);
                it  = {OP_READ, 12'($urandom_range(0, frame_px - 1)), 24'($urandom)};
                if (sel < 35) begin
                    it.op = OP_LOAD;
                end else if (sel < 42) begin
                    it.op = OP_LOAD;
                    if (frame_px < DEPTH)
                        it.pixel_index = 12'($urandom_range(frame_px, DEPTH - 1));
                end else if (sel < 82 && sel >= 75) begin
                    if (frame_px < DEPTH)
                        it.pixel_index = 12'($urandom_range(frame_px, DEPTH - 1));
                end else if (sel < 89 && sel >= 82) begin
                    it.op          = OP_FILTER;
                    it.pixel_index = 12'($urandom);
                end else if (sel < 94 && sel >= 89) begin
                    it.op          = OP_NONE;
                    it.pixel_index = 12'($urandom);
                end else if (sel >= 97) begin
                    drain_answers();
                end
                sender_gap();
                push_item(it, 1'b0, NO_ANS);
                if (it.op != OP_NONE) random_done++;
            end
        end

        i_in_valid <= 1'b0;
        while (pixel_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
